FILE: src/plfc_pkg.sv
// Shared types and constants for the PMBus linear-format codec.
// Used by every stage module and the top level; depends on nothing.

package plfc_pkg;

  typedef enum logic [1:0] {
    CMD_DEC_S11 = 2'd0,
    CMD_DEC_U16 = 2'd1,
    CMD_ENC_S11 = 2'd2,
    CMD_ENC_U16 = 2'd3
  } cmd_t;

  localparam int unsigned QW = 48;   // Q16 value width
  localparam int unsigned WW = 16;   // PMBus word width
  localparam int unsigned LW = 6;    // leading-one position width
  localparam int unsigned SW = 5;    // shift amount width

  localparam logic [WW-1:0] S11_SAT_WORD = 16'h7BFF;
  localparam logic [WW-1:0] U16_SAT_WORD = 16'hFFFF;
  // 16 + e for a 5-bit two's complement e is e with its top bit flipped
  localparam logic [SW-1:0] EXP_FLIP     = 5'h10;
  localparam logic [SW-1:0] S11_MIN_SH   = 5'd1;   // exponent -15
  localparam logic [LW-1:0] LEAD_SMALL   = 6'd10;  // mantissa fits at exponent -15
  localparam logic [LW-1:0] LEAD_BIAS    = 6'd9;
  localparam logic          CFG_IDX_MODE = 1'b0;
  localparam logic [7:0]    MODE_RESET   = 8'h97;

  typedef struct packed {
    cmd_t            cmd;
    logic [WW-1:0]   raw;
    logic [QW-1:0]   fv;
    logic [SW-1:0]   sh;    // shift for all commands but encode SLINEAR11
    logic [LW-1:0]   lead;  // highest set bit of fv
    logic            nz;
    logic            big;   // no SLINEAR11 exponent fits
  } s1_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [QW-1:0]   val;
    logic [SW-1:0]   sh;
    logic            neg;
    logic            nz;
    logic            big;
  } s2_t;

  typedef struct packed {
    logic [WW-1:0]   word;
    logic [QW-1:0]   dec;
    logic            sat;
  } res_t;

endpackage

FILE: src/pmbus_linear_format_codec.sv
// Channel  | Dir | Beat contents
// in_      | in  | tuser: command; tdata: raw_word, fixed_value
// out_     | out | tdata: encoded_word, decoded_value, saturated
// cfg_     | in  | APB register: output_voltage_mode at byte 0
//
// One beat per cycle sustained while out_ is not stalled; a beat taken on in_ passes
// through three register stages on the way to out_.
// The depth is set by the three stages: leading-one search, barrel shift, pack.
// rst_n (synchronous) empties the pipe and sets the mode register to 0x97.
// A stall holds every full stage; an empty stage still takes a beat.
// Top level of the PMBus linear codec; depends on plfc_pkg and the stage modules.

module pmbus_linear_format_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [15:0] raw_word, [63:16] fixed_value
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [15:0] encoded_word, [63:16] decoded_value,
                                  // [64] saturated, [71:65] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]     mode_r, mode_nxt;
  logic           cfg_wr;
  logic           v1, r1, v2, r2;
  plfc_pkg::s1_t  d1;
  plfc_pkg::s2_t  d2;
  plfc_pkg::res_t res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign mode_nxt   = (cfg_wr && cfg_paddr[2] == plfc_pkg::CFG_IDX_MODE) ?
                      cfg_pwdata[7:0] : mode_r;
  assign cfg_prdata = (cfg_paddr[2] == plfc_pkg::CFG_IDX_MODE) ? {24'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= plfc_pkg::MODE_RESET;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  plfc_lead u_lead (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .cmd      (plfc_pkg::cmd_t'(in_tuser)),
    .raw      (in_tdata[15:0]),
    .fv       (in_tdata[63:16]),
    .mode_exp (mode_r[4:0]),
    .dn_valid (v1),
    .dn_ready (r1),
    .dn_data  (d1)
  );

  plfc_shift u_shift (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v1),
    .up_ready (r1),
    .up_data  (d1),
    .dn_valid (v2),
    .dn_ready (r2),
    .dn_data  (d2)
  );

  plfc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v2),
    .up_ready (r2),
    .up_data  (d2),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res)
  );

  assign out_tdata = {7'd0, res.sat, res.dec, res.word};

`ifndef ASSERT_OFF
  // backpressure only reaches the input through a full, stalled output
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output stall");

  // a saturated beat carries one of the two clamp words
  a_sat_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[64]) |->
      (out_tdata[15:0] == plfc_pkg::S11_SAT_WORD ||
       out_tdata[15:0] == plfc_pkg::U16_SAT_WORD))
    else $error("saturation flag with wrong word");

  // decode and encode results never mix in one beat
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (|out_tdata[63:16])) |-> (out_tdata[15:0] == '0 && !out_tdata[64]))
    else $error("decoded value alongside encode fields");

  // a write to the mode register lands on the next edge
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_paddr[2] == plfc_pkg::CFG_IDX_MODE) |=>
      (mode_r == $past(cfg_pwdata[7:0])))
    else $error("mode register write lost");
`endif

endmodule

FILE: src/plfc_lead.sv
// Stage 1: leading-one search on the encode value and shift selection.
// Depends on plfc_pkg.

module plfc_lead (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  plfc_pkg::cmd_t      cmd,
  input  logic [15:0]         raw,
  input  logic [47:0]         fv,
  input  logic [4:0]          mode_exp,
  output logic                dn_valid,
  input  logic                dn_ready,
  output plfc_pkg::s1_t       dn_data
);

  logic          valid_r, valid_nxt;
  plfc_pkg::s1_t data_r, data_nxt;
  logic [plfc_pkg::LW-1:0] lead;

  always_comb begin
    lead = '0;
    for (int i = 0; i < plfc_pkg::QW; i++) begin
      if (fv[i]) lead = plfc_pkg::LW'(i);
    end
  end

  always_comb begin
    data_nxt      = '0;
    data_nxt.cmd  = cmd;
    data_nxt.raw  = raw;
    data_nxt.fv   = fv;
    data_nxt.lead = lead;
    data_nxt.nz   = |fv;
    data_nxt.big  = |fv[46:41];
    if (cmd == plfc_pkg::CMD_DEC_S11) begin
      data_nxt.sh = raw[15:11] ^ plfc_pkg::EXP_FLIP;
    end else begin
      data_nxt.sh = mode_exp ^ plfc_pkg::EXP_FLIP;
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: src/plfc_shift.sv
// Stage 2: barrel shifts, left for decode and right for encode.
// Depends on plfc_pkg.

module plfc_shift (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  plfc_pkg::s1_t       up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output plfc_pkg::s2_t       dn_data
);

  logic          valid_r, valid_nxt;
  plfc_pkg::s2_t data_r, data_nxt;
  logic [plfc_pkg::SW-1:0] sh;
  logic [plfc_pkg::LW-1:0] lead_adj;
  logic [plfc_pkg::QW-1:0] opnd;

  assign lead_adj = up_data.lead - plfc_pkg::LEAD_BIAS;

  always_comb begin
    sh = up_data.sh;
    if (up_data.cmd == plfc_pkg::CMD_ENC_S11) begin
      // smallest exponent keeping the mantissa under 1024, floored at -15
      if (up_data.lead <= plfc_pkg::LEAD_SMALL) sh = plfc_pkg::S11_MIN_SH;
      else sh = lead_adj[plfc_pkg::SW-1:0];
    end
  end

  always_comb begin
    if (up_data.cmd == plfc_pkg::CMD_DEC_S11) begin
      opnd = {{37{up_data.raw[10]}}, up_data.raw[10:0]};
    end else begin
      opnd = {32'd0, up_data.raw};
    end
  end

  always_comb begin
    data_nxt     = '0;
    data_nxt.cmd = up_data.cmd;
    data_nxt.sh  = sh;
    data_nxt.neg = up_data.fv[plfc_pkg::QW-1];
    data_nxt.nz  = up_data.nz;
    data_nxt.big = up_data.big;
    if (up_data.cmd == plfc_pkg::CMD_DEC_S11 || up_data.cmd == plfc_pkg::CMD_DEC_U16) begin
      data_nxt.val = opnd << sh;
    end else begin
      data_nxt.val = up_data.fv >> sh;
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: src/plfc_pack.sv
// Stage 3: word packing, saturation and the output register.
// Depends on plfc_pkg.

module plfc_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  plfc_pkg::s2_t       up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output plfc_pkg::res_t      dn_data
);

  logic           valid_r, valid_nxt;
  plfc_pkg::res_t data_r, data_nxt;

  always_comb begin
    data_nxt = '0;
    unique case (up_data.cmd)
      plfc_pkg::CMD_DEC_S11,
      plfc_pkg::CMD_DEC_U16: begin
        data_nxt.dec = up_data.val;
      end
      plfc_pkg::CMD_ENC_S11: begin
        if (!up_data.neg && up_data.nz) begin
          if (up_data.big) begin
            data_nxt.word = plfc_pkg::S11_SAT_WORD;
            data_nxt.sat  = 1'b1;
          end else begin
            data_nxt.word = {up_data.sh ^ plfc_pkg::EXP_FLIP, up_data.val[10:0]};
          end
        end
      end
      plfc_pkg::CMD_ENC_U16: begin
        if (!up_data.neg) begin
          if (|up_data.val[plfc_pkg::QW-1:plfc_pkg::WW]) begin
            data_nxt.word = plfc_pkg::U16_SAT_WORD;
            data_nxt.sat  = 1'b1;
          end else begin
            data_nxt.word = up_data.val[plfc_pkg::WW-1:0];
          end
        end
      end
      default: data_nxt = '0;
    endcase
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
